/* hw/rtl/bmf_pkg.sv */
// Shared types and constants of the 3x3 box mean filter.
`default_nettype none
package bmf_pkg;

	localparam int MAX_WIDTH = 256;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = 12;
	localparam int PIX_W = 8;
	localparam int COLSUM_W = 10;
	localparam int SUM_W = 12;

	// floor(s / 9) equals (s * 7282) >> 16 for every s up to 2295.
	localparam int RECIP_SHIFT = 16;
	localparam logic [SUM_W:0] RECIP9 = 13'd7282;
	localparam int PROD_W = 2 * SUM_W + 1;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	localparam int CLAMP_W = 8;
	localparam int WIDTH_W = 9;
	localparam int HEIGHT_W = 13;

	localparam logic [CLAMP_W-1:0] CLAMP_RESET = 8'd225;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 9'd256;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd256;
	localparam logic [WIDTH_W-1:0] WIDTH_MIN = 9'd3;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX = 9'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 13'd3;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 13'd4096;

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_CLAMP_HIGH = 2'd0;
	localparam logic [1:0] REG_LINE_WIDTH = 2'd1;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

	typedef struct packed {
		logic [CLAMP_W-1:0] clamp_high;
		logic [WIDTH_W-1:0] line_width;
		logic [HEIGHT_W-1:0] frame_height;
	} cfg_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic last;
	} sum_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] above;
		logic [PIX_W-1:0] two_above;
	} line_t;

endpackage
`default_nettype wire

/* hw/rtl/box_mean_filter_3x3.sv */
// Top level of the 3x3 box mean filter with its configuration registers.
//
// Pixels enter on the s_ stream in raster order, one beat per pixel; tuser
// marks the first pixel of a frame and resets the row and column position.
// For each pixel that completes an interior 3x3 window, one beat leaves on
// the m_ stream: the floored mean of the nine pixels, capped at clamp_high,
// with tlast on the last interior pixel of the frame. Border pixels give no
// output beat. Frames also wrap by themselves after frame_height rows.
// Throughput is one pixel per clock while s_tready is high, set by the
// single line store port pair (one read, one write per cycle). A pixel
// passes the s1, s2, queue, product and output registers in turn.
// A receiver stall fills the four-entry queue between the window sum and
// the divider; s_tready drops when the queue plus items in flight would
// overflow it. Reset clears the position counters, the pipeline valids and
// the queue and loads clamp_high 225, line_width 256, frame_height 256; the
// line store holds no valid data until a row has been written.
// Registers on the APB port: clamp_high at 0x0, line_width at 0x4,
// frame_height at 0x8. Write them only while the stream is idle.
`default_nettype none
module box_mean_filter_3x3 (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [bmf_pkg::ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata,  // pixel
	input wire logic s_tuser,        // frame_start
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata,      // mean_value
	output logic m_tlast             // last_of_frame
);

	bmf_pkg::cfg_t cfg_q;
	logic wr_en;
	logic push, pop, q_empty;
	bmf_pkg::sum_item_t push_item, q_head;
	logic [bmf_pkg::Q_CNT_W-1:0] q_count;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clamp_high <= bmf_pkg::CLAMP_RESET;
			cfg_q.line_width <= bmf_pkg::WIDTH_RESET;
			cfg_q.frame_height <= bmf_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				bmf_pkg::REG_CLAMP_HIGH: cfg_q.clamp_high <= pwdata[bmf_pkg::CLAMP_W-1:0];
				bmf_pkg::REG_LINE_WIDTH: cfg_q.line_width <= pwdata[bmf_pkg::WIDTH_W-1:0];
				bmf_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= pwdata[bmf_pkg::HEIGHT_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bmf_pkg::REG_CLAMP_HIGH: prdata = 32'(cfg_q.clamp_high);
			bmf_pkg::REG_LINE_WIDTH: prdata = 32'(cfg_q.line_width);
			bmf_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_q.frame_height);
			default: prdata = '0;
		endcase
	end

	bmf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.q_count(q_count),
		.push(push),
		.push_item(push_item)
	);

	bmf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.empty(q_empty),
		.head(q_head),
		.count(q_count)
	);

	bmf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule
`default_nettype wire

/* hw/rtl/bmf_front.sv */
// Front end: raster position, line store, column sums and window sum.
`default_nettype none
module bmf_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire bmf_pkg::cfg_t cfg,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata,  // pixel
	input wire logic s_tuser,        // frame_start
	input wire logic [bmf_pkg::Q_CNT_W-1:0] q_count,
	output logic push,
	output bmf_pkg::sum_item_t push_item
);

	logic accept;
	logic [bmf_pkg::COL_W-1:0] c_q, c_cur, wm1;
	logic [bmf_pkg::ROW_W-1:0] r_q, r_cur, hm1;
	logic [bmf_pkg::WIDTH_W-1:0] w_eff;
	logic [bmf_pkg::HEIGHT_W-1:0] h_eff;
	logic row_end, frame_end;

	logic v_s1, emit_s1, last_s1;
	logic [bmf_pkg::PIX_W-1:0] px_s1;
	logic [bmf_pkg::COL_W-1:0] c_s1;
	bmf_pkg::line_t rd_q, fwd_data_q, rd_eff;
	logic fwd_q;
	bmf_pkg::line_t line_mem [bmf_pkg::MAX_WIDTH];

	logic [bmf_pkg::COLSUM_W-1:0] colsum, cs_old_q, cs_new_q;
	logic v_s2, last_s2;
	logic [bmf_pkg::SUM_W-1:0] sum_s2;

	// Every item in flight may still need a queue slot.
	assign s_tready = ({1'b0, q_count} + {{bmf_pkg::Q_CNT_W{1'b0}}, v_s1}
		+ {{bmf_pkg::Q_CNT_W{1'b0}}, v_s2}) < (bmf_pkg::Q_CNT_W + 1)'(bmf_pkg::Q_DEPTH);
	assign accept = s_tvalid & s_tready;

	always_comb begin
		w_eff = cfg.line_width;
		if (w_eff < bmf_pkg::WIDTH_MIN) w_eff = bmf_pkg::WIDTH_MIN;
		if (w_eff > bmf_pkg::WIDTH_MAX) w_eff = bmf_pkg::WIDTH_MAX;
		h_eff = cfg.frame_height;
		if (h_eff < bmf_pkg::HEIGHT_MIN) h_eff = bmf_pkg::HEIGHT_MIN;
		if (h_eff > bmf_pkg::HEIGHT_MAX) h_eff = bmf_pkg::HEIGHT_MAX;
	end

	assign wm1 = bmf_pkg::COL_W'(w_eff - 9'd1);
	assign hm1 = bmf_pkg::ROW_W'(h_eff - 13'd1);
	assign c_cur = s_tuser ? '0 : c_q;
	assign r_cur = s_tuser ? '0 : r_q;
	assign row_end = c_cur >= wm1;
	assign frame_end = r_cur >= hm1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1 & emit_s1;
			if (accept) begin
				if (row_end) begin
					c_q <= '0;
					r_q <= frame_end ? '0 : r_cur + 1'b1;
				end else begin
					c_q <= c_cur + 1'b1;
					r_q <= r_cur;
				end
			end
		end
	end

	// A pixel at the same column as the one just before it (two frame starts
	// in a row) must see that pixel's line store update, which lands in the
	// cycle after the read.
	assign rd_eff = fwd_q ? fwd_data_q : rd_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= s_tdata;
			c_s1 <= c_cur;
			emit_s1 <= (r_cur >= 12'd2) && (c_cur >= 8'd2);
			last_s1 <= frame_end && row_end;
			rd_q <= line_mem[c_cur];
			fwd_q <= v_s1 && (c_cur == c_s1);
			fwd_data_q <= '{above: px_s1, two_above: rd_eff.above};
		end
		if (v_s1) begin
			line_mem[c_s1] <= '{above: px_s1, two_above: rd_eff.above};
		end
	end

	assign colsum = bmf_pkg::COLSUM_W'(rd_eff.two_above) + bmf_pkg::COLSUM_W'(rd_eff.above)
		+ bmf_pkg::COLSUM_W'(px_s1);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			cs_old_q <= cs_new_q;
			cs_new_q <= colsum;
			sum_s2 <= bmf_pkg::SUM_W'(cs_old_q) + bmf_pkg::SUM_W'(cs_new_q)
				+ bmf_pkg::SUM_W'(colsum);
			last_s2 <= last_s1;
		end
	end

	assign push = v_s2;
	assign push_item = '{sum: sum_s2, last: last_s2};

endmodule
`default_nettype wire

/* hw/rtl/bmf_queue.sv */
// Short first-word-fall-through queue between front and back end.
`default_nettype none
module bmf_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire bmf_pkg::sum_item_t push_item,
	input wire logic pop,
	output logic empty,
	output bmf_pkg::sum_item_t head,
	output logic [bmf_pkg::Q_CNT_W-1:0] count
);

	bmf_pkg::sum_item_t q_mem [bmf_pkg::Q_DEPTH];
	logic [bmf_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [bmf_pkg::Q_CNT_W-1:0] count_q;
	logic do_pop;

	assign empty = count_q == '0;
	assign do_pop = pop & ~empty;
	assign head = q_mem[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + {{(bmf_pkg::Q_CNT_W-1){1'b0}}, push}
				- {{(bmf_pkg::Q_CNT_W-1){1'b0}}, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

/* hw/rtl/bmf_back.sv */
// Back end: divide the window sum by nine, cap it and hold the output beat.
`default_nettype none
module bmf_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire bmf_pkg::cfg_t cfg,
	input wire logic q_empty,
	input wire bmf_pkg::sum_item_t q_head,
	output logic q_pop,
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tdata,  // mean_value
	output logic m_tlast         // last_of_frame
);

	logic v_b1, last_b1, load_b1, load_b2;
	logic [bmf_pkg::PROD_W-1:0] prod_b1;
	logic [bmf_pkg::PIX_W-1:0] mean_b1, capped_b1;

	assign load_b2 = v_b1 & (~m_tvalid | m_tready);
	assign load_b1 = ~v_b1 | load_b2;
	assign q_pop = load_b1 & ~q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (load_b1) v_b1 <= ~q_empty;
			if (load_b2) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	assign mean_b1 = bmf_pkg::PIX_W'(prod_b1 >> bmf_pkg::RECIP_SHIFT);
	assign capped_b1 = (mean_b1 > cfg.clamp_high) ? cfg.clamp_high : mean_b1;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_b1 <= bmf_pkg::PROD_W'(q_head.sum) * bmf_pkg::PROD_W'(bmf_pkg::RECIP9);
			last_b1 <= q_head.last;
		end
		if (load_b2) begin
			m_tdata <= capped_b1;
			m_tlast <= last_b1;
		end
	end

endmodule
`default_nettype wire
